/* design/fapc_pkg.sv */
// Shared widths, register codes, reset values and the word type of the flap angle converter.
package fapc_pkg;

    localparam int VAL_W      = 23;
    localparam int OPD_W      = 24;
    localparam int COEF_W     = 40;
    localparam int ACC_W      = 56;
    localparam int CFG_IDX_W  = 3;

    localparam int BISECT_STEPS_DEF = 24;
    localparam int FRAC_BITS_DEF    = 16;

    localparam logic signed [ACC_W+1:0] SAT_MAX = 58'sh7FFFFFFFFFFFFF;

    localparam logic signed [COEF_W-1:0] RST_COEF_CONST  = 40'sd8160437862;
    localparam logic signed [COEF_W-1:0] RST_COEF_LINEAR = 40'sd1979979923;
    localparam logic signed [COEF_W-1:0] RST_COEF_SQUARE = -40'sd25426206;
    localparam logic signed [COEF_W-1:0] RST_COEF_CUBE   = 40'sd269724;
    localparam logic [VAL_W-1:0]         RST_MAX_ANGLE   = 23'd4784128;
    localparam logic [VAL_W-1:0]         RST_MAX_POS     = 23'd1867776;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_CONST  = 3'd0,
        REG_COEF_LINEAR = 3'd1,
        REG_COEF_SQUARE = 3'd2,
        REG_COEF_CUBE   = 3'd3,
        REG_MAX_ANGLE   = 3'd4,
        REG_MAX_POS     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic                    valid;
        logic                    op;
        logic [VAL_W-1:0]        low;
        logic [VAL_W-1:0]        high;
        logic signed [ACC_W-1:0] target;
        logic [VAL_W-1:0]        res;
    } t_side;

    function automatic logic signed [ACC_W-1:0] sat55(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W+1:0] r;
        begin
            r = v;
            if (v > SAT_MAX) r = SAT_MAX;
            if (v < -SAT_MAX) r = -SAT_MAX;
            sat55 = r[ACC_W-1:0];
        end
    endfunction

endpackage

/* design/fapc_cubic.sv */
// Pipelined Horner evaluation of the calibrated cubic, two stages per coefficient.
module fapc_cubic
    import fapc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [VAL_W-1:0]         i_x,
    input  t_side                    i_side,
    input  logic signed [COEF_W-1:0] i_c0,
    input  logic signed [COEF_W-1:0] i_c1,
    input  logic signed [COEF_W-1:0] i_c2,
    input  logic signed [COEF_W-1:0] i_c3,
    output logic signed [ACC_W-1:0]  o_p,
    output t_side                    o_side
);

    localparam int S = 32 - FRAC_BITS;
    localparam logic [54:0] SAT_U  = 55'h7FFFFFFFFFFFFF;
    localparam logic [45:0] HI_LIM = 46'(SAT_U >> S);

    logic [45:0]             r_hi  [3];
    logic [54:0]             r_lo  [3];
    logic                    r_neg [3];
    logic [VAL_W-1:0]        r_xa  [3];
    logic                    r_za  [3];
    t_side                   r_sa  [3];
    logic signed [ACC_W-1:0] r_acc [3];
    logic [VAL_W-1:0]        r_xb  [3];
    logic                    r_zb  [3];
    t_side                   r_sb  [3];

    logic signed [COEF_W-1:0] w_cf [3];
    assign w_cf[0] = i_c2;
    assign w_cf[1] = i_c1;
    assign w_cf[2] = i_c0;

    for (genvar j = 0; j < 3; j++) begin : g_step
        logic signed [ACC_W-1:0]   acc_in;
        logic [VAL_W-1:0]          x_in;
        logic                      z_in;
        t_side                     s_in;
        logic [ACC_W-1:0]          mag;
        logic [45:0]               n_hi;
        logic [54:0]               n_lo;
        logic [56:0]               sum;
        logic [54:0]               t;
        logic signed [ACC_W+1:0]   sv;
        logic signed [ACC_W+1:0]   tot;
        logic signed [ACC_W-1:0]   n_acc;

        if (j == 0) begin : g_first
            assign acc_in = {{(ACC_W-COEF_W){i_c3[COEF_W-1]}}, i_c3};
            assign x_in   = i_x;
            assign z_in   = (i_x == '0);
            assign s_in   = i_side;
        end else begin : g_next
            assign acc_in = r_acc[j-1];
            assign x_in   = r_xb[j-1];
            assign z_in   = r_zb[j-1];
            assign s_in   = r_sb[j-1];
        end

        assign mag  = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : ACC_W'(acc_in);
        assign n_hi = mag[54:32] * x_in;
        assign n_lo = mag[31:0] * x_in;

        assign sum = (57'(r_hi[j]) << S) + 57'(r_lo[j] >> FRAC_BITS);
        assign t   = (r_hi[j] > HI_LIM || sum > 57'(SAT_U)) ? SAT_U : sum[54:0];
        assign sv  = r_neg[j] ? -$signed({3'b000, t}) : $signed({3'b000, t});
        assign tot = sv + {{(ACC_W+2-COEF_W){w_cf[j][COEF_W-1]}}, w_cf[j]};
        assign n_acc = sat55(tot);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sa[j].valid <= 1'b0;
                r_sb[j].valid <= 1'b0;
            end else if (i_en) begin
                r_hi[j]  <= n_hi;
                r_lo[j]  <= n_lo;
                r_neg[j] <= acc_in[ACC_W-1];
                r_xa[j]  <= x_in;
                r_za[j]  <= z_in;
                r_sa[j]  <= s_in;
                r_acc[j] <= n_acc;
                r_xb[j]  <= r_xa[j];
                r_zb[j]  <= r_za[j];
                r_sb[j]  <= r_sa[j];
            end
        end
    end

    assign o_p    = r_zb[2] ? '0 : r_acc[2];
    assign o_side = r_sb[2];

endmodule

/* design/flap_angle_position_converter.sv */
// Top level: angle to position by the cubic, position to angle by pipelined bisection.
// Path: input register, then one cubic unit per bisection step, then the output register.
// Throughput: one word per cycle while the output is not stalled; each bisection step has its own six-stage cubic unit.
// Stall: the whole pipeline holds while the output word is held by a stall.
// Reset: synchronous active low; clears all valid bits and loads the calibration values.
module flap_angle_position_converter
    import fapc_pkg::*;
#(
    parameter int BISECT_STEPS = BISECT_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_opcode,
    input  logic signed [OPD_W-1:0] i_operand_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [VAL_W-1:0]     o_converted_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    localparam int S = 32 - FRAC_BITS;

    logic signed [COEF_W-1:0] r_c0, r_c1, r_c2, r_c3;
    logic [VAL_W-1:0]         r_max_ang, r_max_pos;

    logic                     en;
    t_side                    r_s0;
    logic [VAL_W-1:0]         r_x0;
    logic                     r_out_valid;
    logic [VAL_W-1:0]         r_out_val;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_converted_value = r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0      <= RST_COEF_CONST;
            r_c1      <= RST_COEF_LINEAR;
            r_c2      <= RST_COEF_SQUARE;
            r_c3      <= RST_COEF_CUBE;
            r_max_ang <= RST_MAX_ANGLE;
            r_max_pos <= RST_MAX_POS;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_COEF_CONST:  r_c0 <= i_cfg_data;
                REG_COEF_LINEAR: r_c1 <= i_cfg_data;
                REG_COEF_SQUARE: r_c2 <= i_cfg_data;
                REG_COEF_CUBE:   r_c3 <= i_cfg_data;
                REG_MAX_ANGLE:   r_max_ang <= i_cfg_data[VAL_W-1:0];
                REG_MAX_POS:     r_max_pos <= i_cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    logic [VAL_W-1:0] lim, clamped;
    t_side            n_s0;
    logic [VAL_W-1:0] n_x0;

    always_comb begin
        lim = i_opcode ? r_max_pos : r_max_ang;
        if (i_operand_value[OPD_W-1])
            clamped = '0;
        else if (i_operand_value[VAL_W-1:0] > lim)
            clamped = lim;
        else
            clamped = i_operand_value[VAL_W-1:0];
        n_s0.valid  = i_in_valid;
        n_s0.op     = i_opcode;
        n_s0.low    = '0;
        n_s0.high   = r_max_ang;
        n_s0.target = ACC_W'(clamped) << S;
        n_s0.res    = '0;
        n_x0        = i_opcode ? (r_max_ang >> 1) : clamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
            r_x0 <= n_x0;
        end
    end

    t_side                   s_in  [BISECT_STEPS+1];
    logic [VAL_W-1:0]        x_in  [BISECT_STEPS+1];
    t_side                   s_out [BISECT_STEPS];
    logic signed [ACC_W-1:0] p_out [BISECT_STEPS];

    assign s_in[0] = r_s0;
    assign x_in[0] = r_x0;

    for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_bis
        logic [VAL_W:0]          sum_old, sum_new;
        logic [VAL_W-1:0]        mid;
        logic                    lt;
        logic signed [ACC_W-1:0] q;
        t_side                   upd;

        fapc_cubic #(.FRAC_BITS(FRAC_BITS)) u_cubic (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_x    (x_in[k]),
            .i_side (s_in[k]),
            .i_c0   (r_c0),
            .i_c1   (r_c1),
            .i_c2   (r_c2),
            .i_c3   (r_c3),
            .o_p    (p_out[k]),
            .o_side (s_out[k])
        );

        always_comb begin
            upd     = s_out[k];
            sum_old = {1'b0, s_out[k].low} + {1'b0, s_out[k].high};
            mid     = sum_old[VAL_W:1];
            lt      = p_out[k] < s_out[k].target;
            q       = p_out[k] >>> S;
            if (s_out[k].op) begin
                if (lt) upd.low  = mid;
                else    upd.high = mid;
            end else if (k == 0) begin
                if (p_out[k][ACC_W-1])
                    upd.res = '0;
                else if (q > $signed(ACC_W'(r_max_pos)))
                    upd.res = r_max_pos;
                else
                    upd.res = q[VAL_W-1:0];
            end
            sum_new = {1'b0, upd.low} + {1'b0, upd.high};
        end

        assign s_in[k+1] = upd;
        assign x_in[k+1] = sum_new[VAL_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s_in[BISECT_STEPS].valid;
            r_out_val   <= s_in[BISECT_STEPS].op ? x_in[BISECT_STEPS] : s_in[BISECT_STEPS].res;
        end
    end

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a held output word");

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_s0) && $stable(r_x0))
        else $error("front stage moved during a stall");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out_val <= r_max_pos || r_out_val <= r_max_ang))
        else $error("output word beyond both limits");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the flap angle / motor position converter.
module testbench;
    import fapc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS    = BISECT_STEPS_DEF;
    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int LATENCY  = 6 * STEPS + 2;
    localparam logic OP_ANGLE_TO_POS = 1'b0;
    localparam logic OP_POS_TO_ANGLE = 1'b1;
    localparam longint ACC_LIMIT = 64'sh007FFFFFFFFFFFFF;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_opcode;
    logic signed [OPD_W-1:0] i_operand_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [VAL_W-1:0]        o_converted_value;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [COEF_W-1:0]       i_cfg_data;

    flap_angle_position_converter dut (.*);

    typedef struct {
        logic             op;
        logic [OPD_W-1:0] operand;
        logic             known;
        logic [VAL_W-1:0] value;
    } t_row;

    longint      cal_const, cal_linear, cal_square, cal_cube;
    int unsigned lim_angle, lim_pos;

    logic [VAL_W-1:0] pending_values[$];
    int  errors;
    int  in_idle_pct;
    int  out_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    function automatic longint clip55(longint v);
        if (v > ACC_LIMIT) return ACC_LIMIT;
        if (v < -ACC_LIMIT) return -ACC_LIMIT;
        return v;
    endfunction

    function automatic longint scale_by(longint acc, int unsigned x);
        logic            neg;
        longint unsigned m, hi, lo, t;
        neg = acc < 0;
        m   = neg ? longint'(-acc) : acc;
        hi  = (m >> 32) * x;
        lo  = (m & 64'hFFFFFFFF) * x;
        if (hi > (longint'(ACC_LIMIT) >> (32 - FRAC))) begin
            t = ACC_LIMIT;
        end else begin
            t = (hi << (32 - FRAC)) + (lo >> FRAC);
            if (t > ACC_LIMIT) t = ACC_LIMIT;
        end
        return neg ? -longint'(t) : longint'(t);
    endfunction

    function automatic longint flap_cubic(int unsigned x);
        longint acc;
        if (x == 0) return 0;
        acc = clip55(cal_cube);
        acc = clip55(scale_by(acc, x) + cal_square);
        acc = clip55(scale_by(acc, x) + cal_linear);
        acc = clip55(scale_by(acc, x) + cal_const);
        return acc;
    endfunction

    function automatic int unsigned clamp_in(logic [OPD_W-1:0] raw, int unsigned limit);
        if (raw[OPD_W-1]) return 0;
        return raw > limit ? limit : raw;
    endfunction

    function automatic logic [VAL_W-1:0] convert(logic op, logic [OPD_W-1:0] raw);
        int unsigned x, low, high, mid;
        longint      p, target;
        if (op == OP_ANGLE_TO_POS) begin
            x = clamp_in(raw, lim_angle);
            p = flap_cubic(x);
            if (p < 0) return '0;
            p = p >>> (32 - FRAC);
            return (p > lim_pos) ? lim_pos[VAL_W-1:0] : p[VAL_W-1:0];
        end
        target = longint'(clamp_in(raw, lim_pos)) << (32 - FRAC);
        low    = 0;
        high   = lim_angle;
        for (int i = 0; i < STEPS; i++) begin
            mid = (low + high) >> 1;
            if (flap_cubic(mid) < target) low = mid;
            else high = mid;
        end
        mid = (low + high) >> 1;
        return mid[VAL_W-1:0];
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [COEF_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_COEF_CONST:  cal_const  = longint'($signed(data));
            REG_COEF_LINEAR: cal_linear = longint'($signed(data));
            REG_COEF_SQUARE: cal_square = longint'($signed(data));
            REG_COEF_CUBE:   cal_cube   = longint'($signed(data));
            REG_MAX_ANGLE:   lim_angle  = 32'(data[VAL_W-1:0]);
            REG_MAX_POS:     lim_pos    = 32'(data[VAL_W-1:0]);
            default: ;
        endcase
    endtask

    // hold the driven word until accepted
    task automatic send_word(logic op, logic [OPD_W-1:0] operand, logic known,
                             logic [VAL_W-1:0] value);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_operand_value <= operand;
        do @(posedge i_clk); while (o_in_stall);
        pending_values.push_back(known ? value : convert(op, operand));
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_values.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_values.size() == 0) begin
                    $display("%0t unexpected word: expected none, actual %0d",
                             $realtime, o_converted_value);
                    errors++;
                end else begin
                    if (o_converted_value !== pending_values[0]) begin
                        $display("%0t mismatch: expected %0d, actual %0d", $realtime,
                                 pending_values[0], o_converted_value);
                        errors++;
                    end
                    void'(pending_values.pop_front());
                end
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    task automatic random_burst(int count);
        logic [OPD_W-1:0] v;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: v = OPD_W'($urandom);
                1: v = OPD_W'($urandom_range(lim_angle + 1000));
                2: v = OPD_W'($urandom_range(lim_pos + 1000));
                default: v = ($urandom_range(2) == 0) ? '0 : OPD_W'(lim_angle);
            endcase
            send_word(1'($urandom_range(1)), v, 1'b0, '0);
        end
    endtask

    t_row directed[] = '{
        '{OP_ANGLE_TO_POS, 24'd0,       1'b1, 23'd0},
        '{OP_ANGLE_TO_POS, 24'h800000,  1'b1, 23'd0},
        '{OP_ANGLE_TO_POS, 24'hFFFFFF,  1'b1, 23'd0},
        '{OP_ANGLE_TO_POS, 24'h7FFFFF,  1'b0, 23'd0},
        '{OP_ANGLE_TO_POS, 24'd4784128, 1'b0, 23'd0},
        '{OP_ANGLE_TO_POS, 24'd1,       1'b0, 23'd0},
        '{OP_ANGLE_TO_POS, 24'd655360,  1'b0, 23'd0},
        '{OP_POS_TO_ANGLE, 24'd0,       1'b0, 23'd0},
        '{OP_POS_TO_ANGLE, 24'h800000,  1'b0, 23'd0},
        '{OP_POS_TO_ANGLE, 24'h7FFFFF,  1'b0, 23'd0},
        '{OP_POS_TO_ANGLE, 24'd1867776, 1'b0, 23'd0},
        '{OP_POS_TO_ANGLE, 24'd124518,  1'b0, 23'd0},
        '{OP_POS_TO_ANGLE, 24'd1000000, 1'b0, 23'd0},
        '{OP_POS_TO_ANGLE, 24'h555555,  1'b0, 23'd0},
        '{OP_ANGLE_TO_POS, 24'h2AAAAA,  1'b0, 23'd0}
    };

    initial begin
        errors          = 0;
        in_idle_pct     = 0;
        out_stall_pct   = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_opcode        = 1'b0;
        i_operand_value = '0;
        i_out_stall     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_COEF_CONST;
        i_cfg_data      = '0;
        cal_const       = RST_COEF_CONST;
        cal_linear      = RST_COEF_LINEAR;
        cal_square      = RST_COEF_SQUARE;
        cal_cube        = RST_COEF_CUBE;
        lim_angle       = 32'(RST_MAX_ANGLE);
        lim_pos         = 32'(RST_MAX_POS);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (directed[k])
            send_word(directed[k].op, directed[k].operand, directed[k].known,
                      directed[k].value);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 59; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 59; end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase
            case (phase)
                1: begin
                    write_reg(REG_COEF_CONST,  40'h8000000000);
                    write_reg(REG_COEF_LINEAR, 40'h7FFFFFFFFF);
                    write_reg(REG_COEF_SQUARE, 40'h8000000000);
                    write_reg(REG_COEF_CUBE,   40'h7FFFFFFFFF);
                    write_reg(REG_MAX_ANGLE,   40'h7FFFFF);
                    write_reg(REG_MAX_POS,     40'h7FFFFF);
                    i_cfg_valid <= 1'b0;
                end
                2: begin
                    write_reg(REG_MAX_ANGLE, 40'd0);
                    write_reg(REG_MAX_POS,   40'd0);
                    i_cfg_valid <= 1'b0;
                end
                3, 5, 6: begin
                    write_reg(REG_COEF_CONST,
                              COEF_W'({$urandom, $urandom} >> (24 + $urandom_range(20))));
                    write_reg(REG_COEF_LINEAR, COEF_W'({$urandom, $urandom}));
                    write_reg(REG_COEF_SQUARE,
                              COEF_W'({$urandom, $urandom} >> $urandom_range(30)));
                    write_reg(REG_COEF_CUBE,
                              COEF_W'({$urandom, $urandom} >> $urandom_range(36)));
                    write_reg(REG_MAX_ANGLE,   COEF_W'($urandom_range(23'h7FFFFF)));
                    write_reg(REG_MAX_POS,     COEF_W'($urandom_range(23'h7FFFFF)));
                    i_cfg_valid <= 1'b0;
                end
                4: begin
                    write_reg(REG_COEF_CONST,  RST_COEF_CONST);
                    write_reg(REG_COEF_LINEAR, RST_COEF_LINEAR);
                    write_reg(REG_COEF_SQUARE, RST_COEF_SQUARE);
                    write_reg(REG_COEF_CUBE,   RST_COEF_CUBE);
                    write_reg(REG_MAX_ANGLE,   COEF_W'(RST_MAX_ANGLE));
                    write_reg(REG_MAX_POS,     COEF_W'(RST_MAX_POS));
                    i_cfg_valid <= 1'b0;
                end
                default: ;
            endcase
            random_burst(90);
            if (phase == 0) drain();
            random_burst(90);
            drain();
        end

        out_stall_pct = 0;
        drain();
        if (pending_values.size() != 0) begin
            $display("%0t missing words: expected %0d more, actual none", $realtime,
                     pending_values.size());
            errors++;
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
